>>> rtl/core/pxtc_pkg.sv
// shared types and constants of the pixel triangle coverage block
package pxtc_pkg;

  localparam int unsigned VERT_W   = 24;
  localparam int unsigned EDGE_W   = VERT_W + 1;
  localparam int unsigned NUM_VERT = 3;
  localparam int unsigned CORNERS  = 4;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    COV_OUTSIDE = 2'd0,
    COV_PARTIAL = 2'd1,
    COV_INSIDE  = 2'd2
  } cov_e;

  typedef struct packed {
    logic signed [VERT_W-1:0] x;
    logic signed [VERT_W-1:0] y;
  } point_t;

  typedef point_t [NUM_VERT-1:0] tri_t;

endpackage

>>> rtl/core/pxtc_cfg_regs.sv
// triangle vertex configuration registers
module pxtc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pxtc_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pxtc_pkg::VERT_W-1:0]       cfg_data_i,
  output pxtc_pkg::tri_t                    tri_o
);
  import pxtc_pkg::*;

  tri_t tri_q;
  tri_t tri_d;

  always_comb begin
    tri_d = tri_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_X: tri_d[0].x = signed'(cfg_data_i);
        REG_A_Y: tri_d[0].y = signed'(cfg_data_i);
        REG_B_X: tri_d[1].x = signed'(cfg_data_i);
        REG_B_Y: tri_d[1].y = signed'(cfg_data_i);
        REG_C_X: tri_d[2].x = signed'(cfg_data_i);
        REG_C_Y: tri_d[2].y = signed'(cfg_data_i);
        default: tri_d = tri_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q <= '0;
    end else begin
      tri_q <= tri_d;
    end
  end

  assign tri_o = tri_q;

endmodule

>>> rtl/core/pxtc_edge_mul.sv
// corner placement, edge differences and registered edge products
module pxtc_edge_mul #(
  parameter int unsigned PIXEL_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned DIFF_W     = 25,
  parameter int unsigned PROD_W     = 50
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  pxtc_pkg::tri_t                tri_i,
  input  logic [PIXEL_BITS-1:0]         pixel_x_i,
  input  logic [PIXEL_BITS-1:0]         pixel_y_i,
  output logic signed [PROD_W-1:0]      prod_a_o [pxtc_pkg::CORNERS][pxtc_pkg::NUM_VERT],
  output logic signed [PROD_W-1:0]      prod_b_o [pxtc_pkg::CORNERS][pxtc_pkg::NUM_VERT]
);
  import pxtc_pkg::*;

  localparam int unsigned CORNER_W = PIXEL_BITS + FRAC_BITS + 2;

  logic signed [PROD_W-1:0] prod_a_q [CORNERS][NUM_VERT];
  logic signed [PROD_W-1:0] prod_b_q [CORNERS][NUM_VERT];

  for (genvar k = 0; k < CORNERS; k++) begin : g_corner
    logic [PIXEL_BITS:0]         px_u;
    logic [PIXEL_BITS:0]         py_u;
    logic signed [CORNER_W-1:0]  cx;
    logic signed [CORNER_W-1:0]  cy;

    assign px_u = {1'b0, pixel_x_i} + (PIXEL_BITS+1)'(k % 2);
    assign py_u = {1'b0, pixel_y_i} + (PIXEL_BITS+1)'(k / 2);
    assign cx   = signed'(CORNER_W'(px_u)) <<< FRAC_BITS;
    assign cy   = signed'(CORNER_W'(py_u)) <<< FRAC_BITS;

    for (genvar j = 0; j < NUM_VERT; j++) begin : g_edge
      localparam int unsigned J1 = (j + 1) % NUM_VERT;
      logic signed [EDGE_W-1:0] ex;
      logic signed [EDGE_W-1:0] ey;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;

      assign ex = EDGE_W'(tri_i[J1].x) - EDGE_W'(tri_i[j].x);
      assign ey = EDGE_W'(tri_i[J1].y) - EDGE_W'(tri_i[j].y);
      assign dx = DIFF_W'(cx) - DIFF_W'(tri_i[j].x);
      assign dy = DIFF_W'(cy) - DIFF_W'(tri_i[j].y);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_a_q[k][j] <= PROD_W'(ex) * PROD_W'(dy);
          prod_b_q[k][j] <= PROD_W'(ey) * PROD_W'(dx);
        end
      end
    end
  end

  assign prod_a_o = prod_a_q;
  assign prod_b_o = prod_b_q;

endmodule

>>> rtl/core/pxtc_classify.sv
// edge sign test per corner and registered coverage result
module pxtc_classify #(
  parameter int unsigned PROD_W = 50
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [PROD_W-1:0]      prod_a_i [pxtc_pkg::CORNERS][pxtc_pkg::NUM_VERT],
  input  logic signed [PROD_W-1:0]      prod_b_i [pxtc_pkg::CORNERS][pxtc_pkg::NUM_VERT],
  output logic [1:0]                    coverage_o,
  output logic [pxtc_pkg::CORNERS-1:0]  corner_mask_o
);
  import pxtc_pkg::*;

  logic [CORNERS-1:0] mask_d;
  logic [CORNERS-1:0] mask_q;
  cov_e               cov_d;
  cov_e               cov_q;

  for (genvar k = 0; k < CORNERS; k++) begin : g_corner
    logic [NUM_VERT-1:0] pos;
    logic [NUM_VERT-1:0] neg;

    for (genvar j = 0; j < NUM_VERT; j++) begin : g_edge
      logic signed [PROD_W:0] z;
      assign z      = (PROD_W+1)'(prod_a_i[k][j]) - (PROD_W+1)'(prod_b_i[k][j]);
      assign neg[j] = z[PROD_W];
      assign pos[j] = !z[PROD_W] && (|z);
    end

    assign mask_d[k] = (&pos) || (&neg);
  end

  always_comb begin
    if (mask_d == '0) begin
      cov_d = COV_OUTSIDE;
    end else if (&mask_d) begin
      cov_d = COV_INSIDE;
    end else begin
      cov_d = COV_PARTIAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mask_q <= mask_d;
      cov_q  <= cov_d;
    end
  end

  assign coverage_o    = cov_q;
  assign corner_mask_o = mask_q;

endmodule

>>> rtl/core/pixel_triangle_coverage_top.sv
// top level of the pixel triangle coverage classifier
//
// the triangle is loaded through the write port: cfg_we_i with cfg_idx_i 0..5
// selects a_x, a_y, b_x, b_y, c_x, c_y (signed, FRAC_BITS fraction bits);
// other indexes are ignored; write only while no transaction is in flight
// input channel: in_valid_i / in_stall_o carry pixel_x_i, pixel_y_i, the
// lower-left corner of one pixel; a transaction completes when valid is
// high and stall is low
// output channel: out_valid_o / out_stall_i carry coverage_o (outside,
// partial, inside) and corner_mask_o, one result per input transaction
// a transaction passes in order through the input, edge product and result stages
// throughput: one pixel per cycle while out_stall_i is low; the three register
// stages (input, edge products, result) each pass one transaction per cycle
// a stalled output holds its result; upstream stages keep filling bubbles
// and in_stall_o rises only once the input stage cannot move
// reset clears the vertices to zero and empties all stages
module pixel_triangle_coverage_top #(
  parameter int unsigned PIXEL_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pxtc_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pxtc_pkg::VERT_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PIXEL_BITS-1:0]           pixel_x_i,
  input  logic [PIXEL_BITS-1:0]           pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      coverage_o,
  output logic [pxtc_pkg::CORNERS-1:0]    corner_mask_o
);
  import pxtc_pkg::*;

  localparam int unsigned CORNER_W = PIXEL_BITS + FRAC_BITS + 2;
  localparam int unsigned DIFF_W   = ((CORNER_W > VERT_W) ? CORNER_W : VERT_W) + 1;
  localparam int unsigned PROD_W   = EDGE_W + DIFF_W;

  tri_t                     tri_w;
  logic [PIXEL_BITS-1:0]    pix_x_q;
  logic [PIXEL_BITS-1:0]    pix_y_q;
  logic                     s1_vld_q;
  logic                     s2_vld_q;
  logic                     out_vld_q;
  logic                     adv1;
  logic                     adv2;
  logic                     adv3;
  logic signed [PROD_W-1:0] prod_a [CORNERS][NUM_VERT];
  logic signed [PROD_W-1:0] prod_b [CORNERS][NUM_VERT];

  assign adv3       = !out_vld_q || !out_stall_i;
  assign adv2       = !s2_vld_q || adv3;
  assign adv1       = !s1_vld_q || adv2;
  assign in_stall_o = !adv1;

  pxtc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tri_o      (tri_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_q <= in_valid_i;
      end
      if (adv2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (adv3) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      pix_x_q <= pixel_x_i;
      pix_y_q <= pixel_y_i;
    end
  end

  pxtc_edge_mul #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .DIFF_W     (DIFF_W),
    .PROD_W     (PROD_W)
  ) u_edge (
    .clk_i     (clk_i),
    .en_i      (adv2 && s1_vld_q),
    .tri_i     (tri_w),
    .pixel_x_i (pix_x_q),
    .pixel_y_i (pix_y_q),
    .prod_a_o  (prod_a),
    .prod_b_o  (prod_b)
  );

  pxtc_classify #(
    .PROD_W (PROD_W)
  ) u_class (
    .clk_i         (clk_i),
    .en_i          (adv3 && s2_vld_q),
    .prod_a_i      (prod_a),
    .prod_b_i      (prod_b),
    .coverage_o    (coverage_o),
    .corner_mask_o (corner_mask_o)
  );

  assign out_valid_o = out_vld_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && s2_vld_q && out_vld_q))
    else $error("input stalled with a free stage");

  a_mid_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !adv3) |=> s2_vld_q)
    else $error("product stage dropped a transaction");

  a_inside_full_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && coverage_o == COV_INSIDE) |-> (&corner_mask_o))
    else $error("inside result without all corners");

  a_outside_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && coverage_o == COV_OUTSIDE) |-> (corner_mask_o == '0))
    else $error("outside result with a corner inside");

  a_partial_mixed_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && coverage_o == COV_PARTIAL) |->
      (corner_mask_o != '0 && !(&corner_mask_o)))
    else $error("partial result with uniform corners");

endmodule
